/* sv/dfr_pkg.sv */
package dfr_pkg;

    // sizing
    localparam int BUFFER_BYTES = 1024;
    localparam int PACKET_BYTES = 64;

    localparam int ADDR_W = $clog2(BUFFER_BYTES);
    localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
    localparam int OFF_W  = $clog2(PACKET_BYTES + 2);
    localparam int CALC_W = $clog2(BUFFER_BYTES + PACKET_BYTES + 2);

    // fixed field widths
    localparam int FUNC_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 10;
    localparam int STATE_W    = 3;
    localparam int RX_COUNT_W = 11;
    localparam int WINDOW_W   = 7;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_FILL  = 2'd0;
    localparam logic [1:0] REG_BEGIN = 2'd1;
    localparam logic [1:0] REG_END   = 2'd2;

    typedef enum logic [STATE_W-1:0] {
        ST_IDLE     = 3'd0,
        ST_STANDBY  = 3'd1,
        ST_ARMED    = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_ERROR    = 3'd4,
        ST_COMPLETE = 3'd5
    } rx_state_t;

    typedef enum logic [FUNC_W-1:0] {
        FN_BYTE    = 2'd0,
        FN_ARM     = 2'd1,
        FN_RELEASE = 2'd2,
        FN_READ    = 2'd3
    } func_t;

    typedef struct packed {
        logic [BYTE_W-1:0] fill_byte;
        logic [BYTE_W-1:0] begin_byte;
        logic [BYTE_W-1:0] end_byte;
    } cfg_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } mem_req_t;

    typedef struct packed {
        rx_state_t             rx_state;
        logic [RX_COUNT_W-1:0] rx_count;
        logic                  frame_done;
        logic                  frame_ready;
        logic [WINDOW_W-1:0]   next_window;
        logic                  is_read;
    } result_t;

    // receive window: min(space left, packet size) while armed, else 0
    function automatic logic [CALC_W-1:0] window_of(rx_state_t st, logic [CNT_W-1:0] cnt);
        logic [CALC_W-1:0] space;
        space = CALC_W'(BUFFER_BYTES) - CALC_W'(cnt);
        if (st != ST_ARMED) begin
            return '0;
        end else if (space < CALC_W'(PACKET_BYTES)) begin
            return space;
        end else begin
            return CALC_W'(PACKET_BYTES);
        end
    endfunction

endpackage

/* sv/dfr_buffer.sv */
module dfr_buffer (
    input  logic                                aclk,
    input  dfr_pkg::mem_req_t                   req,
    output logic [dfr_pkg::BYTE_W-1:0]          rd_q
);

    logic [dfr_pkg::BYTE_W-1:0] mem [dfr_pkg::BUFFER_BYTES];

    // single port, registered read; read data holds until the next read
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rd_q <= mem[req.addr];
        end
    end

endmodule

/* sv/dfr_ctrl.sv */
module dfr_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                acc,
    input  dfr_pkg::func_t                      func,
    input  logic [dfr_pkg::BYTE_W-1:0]          data_byte,
    input  logic                                packet_last,
    input  logic                                release_ok,
    input  logic [dfr_pkg::INDEX_W-1:0]         read_index,
    input  dfr_pkg::cfg_t                       cfg,
    output dfr_pkg::mem_req_t                   mem_req,
    output dfr_pkg::result_t                    res
);

    dfr_pkg::rx_state_t             state_reg, state_next;
    logic [dfr_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [dfr_pkg::OFF_W-1:0]      offset_reg, offset_next;
    logic                           seen_reg, seen_next;
    logic                           bad_reg, bad_next;
    logic                           done;
    logic                           wr_hit;

    logic [dfr_pkg::CALC_W-1:0]     win_now;
    logic [dfr_pkg::CALC_W-1:0]     len;
    logic [dfr_pkg::CALC_W-1:0]     pos;
    logic                           rd_in_range;

    assign win_now     = dfr_pkg::window_of(state_reg, count_reg);
    assign pos         = dfr_pkg::CALC_W'(count_reg) + dfr_pkg::CALC_W'(offset_reg);
    assign rd_in_range = int'(read_index) < dfr_pkg::BUFFER_BYTES;

    // next state
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        offset_next = offset_reg;
        seen_next   = seen_reg;
        bad_next    = bad_reg;
        done        = 1'b0;
        wr_hit      = 1'b0;
        len         = '0;
        if (acc) begin
            unique case (func)
                dfr_pkg::FN_BYTE: begin
                    if (state_reg == dfr_pkg::ST_ARMED) begin
                        wr_hit = dfr_pkg::CALC_W'(offset_reg) < win_now;
                        if (count_reg == '0 && !seen_reg && data_byte != cfg.fill_byte) begin
                            seen_next = 1'b1;
                            bad_next  = data_byte != cfg.begin_byte;
                        end
                        // saturates one past the packet size
                        if (int'(offset_reg) <= dfr_pkg::PACKET_BYTES) begin
                            offset_next = offset_reg + 1'b1;
                        end
                        if (packet_last) begin
                            len = dfr_pkg::CALC_W'(offset_next);
                            if (count_reg == '0 && !seen_next) begin
                                // all fill: dropped, still armed
                            end else if (count_reg == '0 && bad_next) begin
                                state_next = dfr_pkg::ST_ERROR;
                            end else if (len > win_now) begin
                                state_next = dfr_pkg::ST_OVERFLOW;
                            end else begin
                                count_next = dfr_pkg::CNT_W'(dfr_pkg::CALC_W'(count_reg) + len);
                                if (data_byte == cfg.end_byte) begin
                                    state_next = dfr_pkg::ST_COMPLETE;
                                    done       = 1'b1;
                                end
                            end
                            offset_next = '0;
                            seen_next   = 1'b0;
                            bad_next    = 1'b0;
                        end
                    end
                end
                dfr_pkg::FN_ARM: begin
                    state_next  = dfr_pkg::ST_ARMED;
                    count_next  = '0;
                    offset_next = '0;
                    seen_next   = 1'b0;
                    bad_next    = 1'b0;
                end
                dfr_pkg::FN_RELEASE: begin
                    state_next  = release_ok ? dfr_pkg::ST_STANDBY : dfr_pkg::ST_ERROR;
                    count_next  = '0;
                    offset_next = '0;
                    seen_next   = 1'b0;
                    bad_next    = 1'b0;
                end
                dfr_pkg::FN_READ: begin
                end
                default: begin
                end
            endcase
        end
    end

    // outputs: buffer access and result fields
    always_comb begin
        mem_req.wr_en = wr_hit;
        mem_req.rd_en = acc && func == dfr_pkg::FN_READ && rd_in_range;
        mem_req.wdata = data_byte;
        if (func == dfr_pkg::FN_READ) begin
            mem_req.addr = dfr_pkg::ADDR_W'(read_index);
        end else begin
            mem_req.addr = dfr_pkg::ADDR_W'(pos);
        end

        res.rx_state    = state_next;
        res.rx_count    = dfr_pkg::RX_COUNT_W'(count_next);
        res.frame_done  = done;
        res.frame_ready = state_next == dfr_pkg::ST_COMPLETE && count_next != '0;
        res.next_window = dfr_pkg::WINDOW_W'(dfr_pkg::window_of(state_next, count_next));
        res.is_read     = func == dfr_pkg::FN_READ && rd_in_range;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= dfr_pkg::ST_IDLE;
            count_reg  <= '0;
            offset_reg <= '0;
            seen_reg   <= 1'b0;
            bad_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            offset_reg <= offset_next;
            seen_reg   <= seen_next;
            bad_reg    <= bad_next;
        end
    end

endmodule

/* sv/dfr_out.sv */
module dfr_out (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                acc,
    input  dfr_pkg::result_t                    res,
    input  logic [dfr_pkg::BYTE_W-1:0]          rd_q,
    output logic                                in_ready,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dfr_pkg::M_TDATA_W-1:0]       m_tdata
);

    logic                           p1_valid_reg, p1_valid_next;
    dfr_pkg::result_t               p1_res_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [dfr_pkg::M_TDATA_W-1:0]  out_data_reg;
    logic [dfr_pkg::M_TDATA_W-1:0]  out_data_next;
    logic [dfr_pkg::BYTE_W-1:0]     rd_byte;
    logic                           out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign in_ready = !p1_valid_reg || out_free;
    assign rd_byte  = p1_res_reg.is_read ? rd_q : '0;

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (acc) begin
            p1_valid_next = 1'b1;
        end else if (out_free) begin
            p1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = p1_valid_reg;
        end
        out_data_next = {1'b0, rd_byte, p1_res_reg.next_window, p1_res_reg.frame_ready,
                         p1_res_reg.frame_done, p1_res_reg.rx_count, p1_res_reg.rx_state};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            p1_res_reg <= res;
        end
        if (out_free && p1_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* sv/delimited_frame_receiver_top.sv */
// An accepted item's result is staged in the holding stage while its buffer access completes, then
// moves into the output register that drives m_tdata.
// Throughput: one item per cycle while m_tready does not stall the output; each item makes at most
// one access to the 1024 x 8 single-port frame buffer, so reads and writes never compete.
// Stalls on m_tready are absorbed by a one-entry holding stage ahead of the output register.
// Reset (aresetn, synchronous, active low) clears the receiver state, config registers and valids;
// the frame buffer itself is not cleared.
module delimited_frame_receiver_top (
    input  logic                                aclk,
    input  logic                                aresetn,

    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] data_byte, [8] release_ok, [18:9] read_index, [23:19] zero
    input  logic [dfr_pkg::S_TDATA_W-1:0]       s_tdata,
    // [1:0] func
    input  logic [dfr_pkg::FUNC_W-1:0]          s_tuser,
    input  logic                                s_tlast,    // packet_last

    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [2:0] rx_state, [13:3] rx_count, [14] frame_done, [15] frame_ready,
    // [22:16] next_window, [30:23] read_data, [31] zero
    output logic [dfr_pkg::M_TDATA_W-1:0]       m_tdata,

    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dfr_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [dfr_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [dfr_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    dfr_pkg::cfg_t          cfg_reg, cfg_next;
    dfr_pkg::mem_req_t      mem_req;
    dfr_pkg::result_t       res;
    logic [dfr_pkg::BYTE_W-1:0] rd_q;
    logic                   acc;
    logic                   cfg_wr;
    logic [1:0]             reg_sel;

    // ------------------------------------------------------------------
    // Configuration registers: 32-bit slots at byte addresses 0, 4, 8.
    // Writes land on the access phase; out-of-range writes are dropped.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            unique case (reg_sel)
                dfr_pkg::REG_FILL:  cfg_next.fill_byte  = pwdata[dfr_pkg::BYTE_W-1:0];
                dfr_pkg::REG_BEGIN: cfg_next.begin_byte = pwdata[dfr_pkg::BYTE_W-1:0];
                dfr_pkg::REG_END:   cfg_next.end_byte   = pwdata[dfr_pkg::BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            dfr_pkg::REG_FILL:  prdata = dfr_pkg::APB_DATA_W'(cfg_reg.fill_byte);
            dfr_pkg::REG_BEGIN: prdata = dfr_pkg::APB_DATA_W'(cfg_reg.begin_byte);
            dfr_pkg::REG_END:   prdata = dfr_pkg::APB_DATA_W'(cfg_reg.end_byte);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Datapath: control registers update on accept and drive one buffer
    // access; the result is staged until the buffer read data is back.
    // ------------------------------------------------------------------
    assign acc = s_tvalid && s_tready;

    dfr_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .acc         (acc),
        .func        (dfr_pkg::func_t'(s_tuser)),
        .data_byte   (s_tdata[7:0]),
        .packet_last (s_tlast),
        .release_ok  (s_tdata[8]),
        .read_index  (s_tdata[18:9]),
        .cfg         (cfg_reg),
        .mem_req     (mem_req),
        .res         (res)
    );

    dfr_buffer u_buffer (
        .aclk (aclk),
        .req  (mem_req),
        .rd_q (rd_q)
    );

    dfr_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .acc      (acc),
        .res      (res),
        .rd_q     (rd_q),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* sv/dfr_checker.sv */
module dfr_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [dfr_pkg::M_TDATA_W-1:0]       m_tdata
);

    // frame_done only with a completed, non-empty frame
    a_done_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[14] |-> m_tdata[2:0] == dfr_pkg::ST_COMPLETE && m_tdata[15])
        else $error("frame_done without completed frame");

    // frame_ready follows state and count
    a_ready_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15] == (m_tdata[2:0] == dfr_pkg::ST_COMPLETE
                                     && m_tdata[13:3] != '0))
        else $error("frame_ready inconsistent");

    // window open only while armed, never above a packet
    a_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[22:16] == '0 || m_tdata[2:0] == dfr_pkg::ST_ARMED)
                     && int'(m_tdata[22:16]) <= dfr_pkg::PACKET_BYTES)
        else $error("receive window out of range");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind delimited_frame_receiver_top dfr_checker u_dfr_checker (.*);

/* bench/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_500_000;

    // one input item as the sender sees it
    typedef struct packed {
        dfr_pkg::func_t                  func;
        logic [dfr_pkg::BYTE_W-1:0]      data;
        logic                            pkt_last;
        logic                            rel_ok;
        logic [dfr_pkg::INDEX_W-1:0]     rd_idx;
    } rx_item_t;

    // one result item, unpacked from m_tdata
    typedef struct packed {
        dfr_pkg::rx_state_t              st;
        logic [dfr_pkg::RX_COUNT_W-1:0]  count;
        logic                            done;
        logic                            ready;
        logic [dfr_pkg::WINDOW_W-1:0]    window;
        logic [dfr_pkg::BYTE_W-1:0]      rdata;
    } rx_status_t;

    // an item waiting to be driven, with the status it must produce
    typedef struct packed {
        rx_item_t   item;
        rx_status_t status;
    } staged_t;

    // ------------------------------------------------------------------
    // clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [dfr_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic [dfr_pkg::FUNC_W-1:0]     s_tuser  = '0;
    logic                           s_tlast  = 1'b0;

    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [dfr_pkg::M_TDATA_W-1:0]  m_tdata;

    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [dfr_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [dfr_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [dfr_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    always #2 aclk = ~aclk;

    delimited_frame_receiver_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // receiver shadow: delimiter settings, frame state and buffer image
    // ------------------------------------------------------------------
    logic [dfr_pkg::BYTE_W-1:0] cfg_fill  = '0;
    logic [dfr_pkg::BYTE_W-1:0] cfg_begin = '0;
    logic [dfr_pkg::BYTE_W-1:0] cfg_end   = '0;

    dfr_pkg::rx_state_t rx_st   = dfr_pkg::ST_IDLE;
    int                 rx_cnt  = 0;
    int                 rx_off  = 0;
    bit                 rx_seen = 1'b0;
    bit                 rx_bad  = 1'b0;

    logic [dfr_pkg::BYTE_W-1:0] shadow  [dfr_pkg::BUFFER_BYTES];
    bit                         written [dfr_pkg::BUFFER_BYTES];
    int                         written_idx [$];     // positions safe to read back

    staged_t           outbound_q [$];      // items not yet driven
    rx_status_t        status_due_q [$];    // statuses owed by the DUT
    staged_t           in_flight;

    int phase_items     = 0;
    int items_driven    = 0;
    int results_checked = 0;
    int frames_done     = 0;
    int overflow_seen   = 0;
    int error_seen      = 0;
    int fault_cnt       = 0;
    int cycle_no        = 0;

    int gap_left   = 0;
    int send_calm  = 0;
    int stall_left = 0;
    int recv_calm  = 0;

    // receive window offered while armed: min(space left, packet size)
    function automatic int rx_window();
        int space;
        if (rx_st != dfr_pkg::ST_ARMED) return 0;
        space = dfr_pkg::BUFFER_BYTES - rx_cnt;
        return (space < dfr_pkg::PACKET_BYTES) ? space : dfr_pkg::PACKET_BYTES;
    endfunction

    // advance the shadow by one item and return the status it yields
    function automatic rx_status_t predict_status(rx_item_t it);
        rx_status_t r;
        int         win;
        int         pos;
        r   = '0;
        win = rx_window();
        case (it.func)
            dfr_pkg::FN_BYTE: begin
                if (rx_st == dfr_pkg::ST_ARMED) begin
                    if (rx_off < win) begin
                        pos = rx_cnt + rx_off;
                        shadow[pos] = it.data;
                        if (!written[pos]) begin
                            written[pos] = 1'b1;
                            written_idx.push_back(pos);
                        end
                    end
                    // leading fill is skipped only at the very start of a frame
                    if (rx_cnt == 0 && !rx_seen && it.data != cfg_fill) begin
                        rx_seen = 1'b1;
                        rx_bad  = (it.data != cfg_begin);
                    end
                    if (rx_off <= dfr_pkg::PACKET_BYTES) rx_off++;
                    if (it.pkt_last) begin
                        // an all-fill opening packet is simply dropped
                        if (rx_cnt != 0 || rx_seen) begin
                            if (rx_cnt == 0 && rx_bad) begin
                                rx_st = dfr_pkg::ST_ERROR;
                            end else if (rx_off > win) begin
                                rx_st = dfr_pkg::ST_OVERFLOW;
                            end else begin
                                rx_cnt += rx_off;
                                if (it.data == cfg_end) begin
                                    rx_st  = dfr_pkg::ST_COMPLETE;
                                    r.done = 1'b1;
                                end
                            end
                        end
                        rx_off  = 0;
                        rx_seen = 1'b0;
                        rx_bad  = 1'b0;
                    end
                end
            end
            dfr_pkg::FN_ARM, dfr_pkg::FN_RELEASE: begin
                rx_cnt  = 0;
                rx_off  = 0;
                rx_seen = 1'b0;
                rx_bad  = 1'b0;
                if (it.func == dfr_pkg::FN_ARM) rx_st = dfr_pkg::ST_ARMED;
                else rx_st = it.rel_ok ? dfr_pkg::ST_STANDBY : dfr_pkg::ST_ERROR;
            end
            default: begin
                r.rdata = shadow[it.rd_idx];
            end
        endcase
        r.st     = rx_st;
        r.count  = dfr_pkg::RX_COUNT_W'(rx_cnt);
        r.ready  = (rx_st == dfr_pkg::ST_COMPLETE && rx_cnt > 0);
        r.window = dfr_pkg::WINDOW_W'(rx_window());
        return r;
    endfunction

    task automatic note_fault(string msg);
        fault_cnt++;
        if (fault_cnt <= 10) $display("MISMATCH %0d: %s", fault_cnt, msg);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // driver: one item per handshake, random gaps between items
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                status_due_q.push_back(in_flight.status);
                items_driven++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (outbound_q.size() > 0) begin
                    in_flight = outbound_q.pop_front();
                    s_tdata   <= {5'b0, in_flight.item.rd_idx, in_flight.item.rel_ok,
                                  in_flight.item.data};
                    s_tuser   <= in_flight.item.func;
                    s_tlast   <= in_flight.item.pkt_last;
                    s_tvalid  <= 1'b1;
                    // occasional back-to-back stretches with no gaps at all
                    if (send_calm > 0) send_calm--;
                    else if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(20, 60);
                    gap_left  <= (send_calm > 0) ? 0 : idle_span();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random back-pressure, every result checked in order
    // ------------------------------------------------------------------
    task automatic check_status(logic [dfr_pkg::M_TDATA_W-1:0] word);
        rx_status_t got;
        rx_status_t want;
        got.st     = dfr_pkg::rx_state_t'(word[2:0]);
        got.count  = word[13:3];
        got.done   = word[14];
        got.ready  = word[15];
        got.window = word[22:16];
        got.rdata  = word[30:23];
        if (status_due_q.size() == 0) begin
            note_fault($sformatf("result %h arrived with nothing expected", word));
        end else begin
            want = status_due_q.pop_front();
            results_checked++;
            if (want.done) frames_done++;
            if (want.st == dfr_pkg::ST_OVERFLOW) overflow_seen++;
            if (want.st == dfr_pkg::ST_ERROR) error_seen++;
            if (got.st !== want.st || got.count !== want.count || got.done !== want.done ||
                got.ready !== want.ready || got.window !== want.window ||
                got.rdata !== want.rdata)
                note_fault($sformatf({"result %0d: exp st=%0d cnt=%0d done=%b rdy=%b win=%0d ",
                    "rd=%h, got st=%0d cnt=%0d done=%b rdy=%b win=%0d rd=%h"},
                    results_checked, want.st, want.count, want.done, want.ready,
                    want.window, want.rdata, got.st, got.count, got.done, got.ready,
                    got.window, got.rdata));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) check_status(m_tdata);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (recv_calm > 0) recv_calm--;
                else if ($urandom_range(0, 49) == 0) recv_calm = $urandom_range(30, 100);
                else if ($urandom_range(0, 3) == 0) stall_left = idle_span();
            end
        end
    end

    // ------------------------------------------------------------------
    // item builders: each item is predicted as it is queued
    // ------------------------------------------------------------------
    function automatic rx_item_t junk_item(dfr_pkg::func_t f);
        rx_item_t it;
        it.func     = f;
        it.data     = dfr_pkg::BYTE_W'($urandom);
        it.pkt_last = 1'($urandom);
        it.rel_ok   = 1'($urandom);
        it.rd_idx   = dfr_pkg::INDEX_W'($urandom);
        return it;
    endfunction

    task automatic queue_item(rx_item_t it);
        staged_t sg;
        sg.item   = it;
        sg.status = predict_status(it);
        outbound_q.push_back(sg);
        phase_items++;
    endtask

    task automatic put_byte(logic [dfr_pkg::BYTE_W-1:0] d, logic lst);
        rx_item_t it;
        it          = junk_item(dfr_pkg::FN_BYTE);
        it.data     = d;
        it.pkt_last = lst;
        queue_item(it);
    endtask

    task automatic put_arm();
        queue_item(junk_item(dfr_pkg::FN_ARM));
    endtask

    task automatic put_release(logic ok);
        rx_item_t it;
        it        = junk_item(dfr_pkg::FN_RELEASE);
        it.rel_ok = ok;
        queue_item(it);
    endtask

    task automatic put_read(int idx);
        rx_item_t it;
        it        = junk_item(dfr_pkg::FN_READ);
        it.rd_idx = dfr_pkg::INDEX_W'(idx);
        queue_item(it);
    endtask

    // read back a position already written, or send a random byte if none is; never touch a fresh entry
    task automatic put_read_any();
        if (written_idx.size() == 0) put_byte(dfr_pkg::BYTE_W'($urandom), 1'($urandom));
        else put_read(written_idx[$urandom_range(0, written_idx.size() - 1)]);
    endtask

    function automatic logic [dfr_pkg::BYTE_W-1:0] other_than(
            logic [dfr_pkg::BYTE_W-1:0] a, logic [dfr_pkg::BYTE_W-1:0] b);
        logic [dfr_pkg::BYTE_W-1:0] d;
        d = dfr_pkg::BYTE_W'($urandom);
        while (d == a || d == b) d = dfr_pkg::BYTE_W'($urandom);
        return d;
    endfunction

    // wait until nothing is queued, on the bus or owed by the DUT
    task automatic drain();
        do @(negedge aclk);
        while (outbound_q.size() != 0 || s_tvalid || status_due_q.size() != 0);
    endtask

    // APB write followed by a readback of the same register
    task automatic reg_write(logic [1:0] idx, logic [dfr_pkg::BYTE_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= dfr_pkg::APB_DATA_W'(val);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        if (prdata !== dfr_pkg::APB_DATA_W'(val))
            note_fault($sformatf("register %0d readback: exp %h, got %h", idx, val, prdata));
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_delimiters(logic [dfr_pkg::BYTE_W-1:0] f,
                                  logic [dfr_pkg::BYTE_W-1:0] b,
                                  logic [dfr_pkg::BYTE_W-1:0] e);
        reg_write(dfr_pkg::REG_FILL, f);
        reg_write(dfr_pkg::REG_BEGIN, b);
        reg_write(dfr_pkg::REG_END, e);
        cfg_fill  = f;
        cfg_begin = b;
        cfg_end   = e;
    endtask

    // arm, optional all-fill packet, then a frame of one or more packets and up to two read-backs,
    // maybe a release; now and then a bad opening byte, a missing end byte or an over-long tail
    task automatic run_frame();
        int                         n_pkts;
        int                         lead;
        int                         len;
        bit                         bad_begin;
        bit                         good_end;
        bit                         long_tail;
        logic [dfr_pkg::BYTE_W-1:0] d;
        n_pkts    = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2);
        lead      = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
        bad_begin = ($urandom_range(0, 9) == 0);
        good_end  = ($urandom_range(0, 5) != 0);
        long_tail = ($urandom_range(0, 11) == 0);
        put_arm();
        if ($urandom_range(0, 5) == 0) begin
            len = $urandom_range(1, 6);
            for (int b = 0; b < len; b++) put_byte(cfg_fill, b == len - 1);
        end
        for (int p = 0; p < n_pkts; p++) begin
            if (p == n_pkts - 1)
                len = long_tail ? $urandom_range(65, 72)
                    : (($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 16));
            else
                len = ($urandom_range(0, 2) == 0) ? 64 : $urandom_range(2, 16);
            if (p == 0 && len < lead + 1) len = lead + 1;
            for (int b = 0; b < len; b++) begin
                if (p == 0 && b < lead)
                    d = cfg_fill;
                else if (p == 0 && b == lead)
                    d = bad_begin ? other_than(cfg_begin, cfg_fill) : cfg_begin;
                else if (b == len - 1)
                    d = (p == n_pkts - 1 && good_end) ? cfg_end : other_than(cfg_end, cfg_end);
                else
                    d = dfr_pkg::BYTE_W'($urandom);
                put_byte(d, b == len - 1);
            end
        end
        repeat ($urandom_range(0, 2)) put_read_any();
        if ($urandom_range(0, 2) == 0) put_release(1'($urandom_range(0, 1)));
    endtask

    // mostly well-formed frames, the rest reads, releases, re-arms and noise;
    // halfway through, the sender holds off until the DUT has caught up
    task automatic random_phase(int target);
        int             r;
        bit             paused;
        dfr_pkg::func_t f;
        phase_items = 0;
        paused      = 1'b0;
        while (phase_items < target) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                run_frame();
            end else if (r < 70) begin
                repeat ($urandom_range(1, 4)) put_read_any();
            end else if (r < 80) begin
                put_release(1'($urandom_range(0, 1)));
            end else if (r < 88) begin
                put_arm();
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    f = dfr_pkg::func_t'($urandom_range(0, 3));
                    if (f == dfr_pkg::FN_READ) put_read_any();
                    else queue_item(junk_item(f));
                end
            end
            if (!paused && phase_items >= target / 2) begin
                drain();
                paused = 1'b1;
            end
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------
    initial begin
        logic [dfr_pkg::BYTE_W-1:0] f;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // delimiters still at reset (all zero): a nonzero opening byte is an error
        put_arm();
        put_byte(8'h00, 1'b0);
        put_byte(8'h05, 1'b1);
        drain();

        // directed: fill FF, begin 00, end FF
        set_delimiters(8'hFF, 8'h00, 8'hFF);
        put_byte(8'h12, 1'b1);      // byte while in error state
        put_release(1'b1);          // to standby
        put_release(1'b0);          // to error
        put_arm();
        put_byte(8'hFF, 1'b0);      // packet of fill only: dropped
        put_byte(8'hFF, 1'b1);
        put_byte(8'hFF, 1'b0);      // wrong opening byte after fill
        put_byte(8'h33, 1'b1);
        put_arm();
        put_byte(8'hFF, 1'b0);      // fill, begin, body
        put_byte(8'h00, 1'b0);
        put_byte(8'h80, 1'b1);
        put_byte(8'h01, 1'b0);      // second packet closes the frame
        put_byte(8'hFF, 1'b1);
        put_read(1);
        put_read(4);
        put_byte(8'h5A, 1'b1);      // after completion: ignored
        put_arm();
        put_read(2);                // buffer survives a re-arm
        put_byte(8'h00, 1'b0);      // begin and end in one packet
        put_byte(8'hFF, 1'b1);
        put_release(1'b1);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       set_delimiters(8'h00, 8'h00, 8'h00);
                1:       set_delimiters(8'hFF, 8'hFF, 8'hFF);
                2:       set_delimiters(8'h7E, 8'hA5, 8'h0D);
                3:       set_delimiters(8'h00, 8'hFF, 8'h00);
                default: set_delimiters(dfr_pkg::BYTE_W'($urandom),
                                        dfr_pkg::BYTE_W'($urandom),
                                        dfr_pkg::BYTE_W'($urandom));
            endcase
            random_phase(80);
        end

        // last setting keeps fill and begin bytes apart
        f = dfr_pkg::BYTE_W'($urandom);
        set_delimiters(f, other_than(f, f), dfr_pkg::BYTE_W'($urandom));
        random_phase(50);

        drain();
        repeat (20) @(posedge aclk);

        $display("%0d items driven over 8 delimiter settings, %0d results checked",
                 items_driven, results_checked);
        $display("%0d frames completed, %0d overflow and %0d error results",
                 frames_done, overflow_seen, error_seen);
        if (fault_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches in total", fault_cnt);
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        while (cycle_no < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_no++;
        end
        $display("cycle limit reached with %0d items queued and %0d results owed",
                 outbound_q.size(), status_due_q.size());
        $display("simulation failed");
        $finish;
    end

endmodule
